// ----- hdl/cia_pkg.sv -----
// Shared types and constants for the compacting integer array.
package cia_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [1:0]         op_t;

  localparam op_t OP_PUSH   = 2'd0;
  localparam op_t OP_SET    = 2'd1;
  localparam op_t OP_GET    = 2'd2;
  localparam op_t OP_DELETE = 2'd3;

  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;

  localparam int COUNT_OUT_W = 9;

  typedef struct packed {
    logic                   status;
    word_t                  read_value;
    logic [COUNT_OUT_W-1:0] entry_count;
  } res_t;

endpackage

// ----- hdl/cia_mem.sv -----
// Entry storage: one write port, one read port with registered read data.
module cia_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cia_pkg::word_t  wdata,
  input  logic [AW-1:0]   raddr,
  output cia_pkg::word_t  rdata
);

  cia_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cia_ctrl.sv -----
// Operation sequencer: decodes each word, drives the entry memory and walks deletes.
module cia_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cia_pkg::op_t        operation,
  input  logic [7:0]          position,
  input  cia_pkg::word_t      value_in,
  output logic                res_valid,
  output cia_pkg::res_t       res,
  input  logic                res_ready,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output cia_pkg::word_t      mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  cia_pkg::word_t      mem_rdata
);

  localparam int PW = (CW > 8) ? CW : 8;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]     state, state_next;
  cia_pkg::op_t   op;
  logic [7:0]     pos;
  cia_pkg::word_t val;
  logic [CW-1:0]  count, count_next;
  logic [AW-1:0]  rp, rp_next;
  logic           pend_valid, pend_valid_next;
  cia_pkg::res_t  pend, pend_next;

  logic           accept;
  logic           in_range;
  logic [AW-1:0]  pos_addr;
  logic [CW-1:0]  count_out;

  assign in_ready  = (state == ST_IDLE) && (!pend_valid || res_ready);
  assign accept    = in_valid && in_ready;
  assign in_range  = PW'(pos) < PW'(count);
  assign pos_addr  = AW'(pos);
  assign res_valid = pend_valid;
  assign res       = pend;

  always_comb begin
    state_next      = state;
    count_next      = count;
    rp_next         = rp;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    mem_we          = 1'b0;
    mem_waddr       = pos_addr;
    mem_wdata       = val;
    mem_raddr       = AW'(position);
    count_out       = count;

    if (pend_valid && res_ready) begin
      pend_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        // read issued straight from the port so get data is ready in EXEC
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        pend_next.status     = 1'b1;
        pend_next.read_value = '0;
        state_next           = ST_IDLE;
        case (op)
          cia_pkg::OP_PUSH: begin
            if (count < CW'(DEPTH) && val != cia_pkg::WORD_MIN &&
                val != cia_pkg::WORD_MAX) begin
              mem_we           = 1'b1;
              mem_waddr        = AW'(count);
              count_out        = count + CW'(1);
              pend_next.status = 1'b0;
            end
          end
          cia_pkg::OP_SET: begin
            if (in_range) begin
              mem_we           = 1'b1;
              pend_next.status = 1'b0;
            end
          end
          cia_pkg::OP_GET: begin
            if (in_range) begin
              pend_next.read_value = mem_rdata;
              pend_next.status     = 1'b0;
            end else begin
              pend_next.read_value = cia_pkg::WORD_MIN;
            end
          end
          cia_pkg::OP_DELETE: begin
            if (in_range) begin
              pend_next.status = 1'b0;
              if (CW'(pos_addr) + CW'(1) < count) begin
                mem_raddr  = pos_addr + AW'(1);
                rp_next    = pos_addr + AW'(1);
                state_next = ST_SHIFT;
              end else begin
                count_out = count - CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
        if (state_next == ST_IDLE) begin
          count_next            = count_out;
          pend_next.entry_count = cia_pkg::COUNT_OUT_W'(count_out);
          pend_valid_next       = 1'b1;
        end
      end
      ST_SHIFT: begin
        // word read at rp arrives now and drops one place down
        mem_we    = 1'b1;
        mem_waddr = rp - AW'(1);
        mem_wdata = mem_rdata;
        if (CW'(rp) + CW'(1) < count) begin
          mem_raddr = rp + AW'(1);
          rp_next   = rp + AW'(1);
        end else begin
          count_out             = count - CW'(1);
          count_next            = count_out;
          pend_next.entry_count = cia_pkg::COUNT_OUT_W'(count_out);
          pend_valid_next       = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rp   <= rp_next;
    pend <= pend_next;
    if (accept) begin
      op  <= operation;
      pos <= position;
      val <= value_in;
    end
  end

endmodule

// ----- hdl/compacting_int_array.sv -----
// Compacting integer array: bounded ordered array of signed words, top level.
//
// Input channel (in_valid/in_ready) carries one operation per word: push,
// set, get or delete, with position and value_in. Output channel
// (out_valid/out_ready) returns one word per operation: status, read_value
// and entry_count after the operation.
// A result is worked out in the EXEC state, held in the sequencer's result
// register and then in the output register; a delete below the top entry
// first walks the SHIFT state, moving each later entry down one place.
// The single memory write port sets the pace of the delete walk, one entry
// per cycle.
// One operation is worked at a time; a new word is taken while the
// previous result still sits in the output register.
// Reset clears the count to zero and empties the output register; the
// entry memory is not cleared, as only entries below the count are read.
// When the receiver stalls, the result holds in the output register and
// one more finished result waits inside; after that the input stalls.
module compacting_int_array #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [7:0]           position,
  input  logic signed [31:0]   value_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic signed [31:0]   read_value,
  output logic [8:0]           entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic           res_valid;
  logic           res_ready;
  cia_pkg::res_t  res;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  cia_pkg::word_t mem_wdata;
  cia_pkg::word_t mem_rdata;

  cia_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .position  (position),
    .value_in  (value_in),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cia_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status      <= res.status;
      read_value  <= res.read_value;
      entry_count <= res.entry_count;
    end
  end

endmodule

// ----- verif/compacting_int_array_check.sv -----
// Checker for the compacting integer array: predicts every result word and compares it.
module compacting_int_array_check #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         position,
  input  logic signed [31:0] value_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               status,
  input  logic signed [31:0] read_value,
  input  logic [8:0]         entry_count,
  output int                 fail_count,
  output int                 outstanding,
  output int                 held_count
);
  timeunit 1ns;
  timeprecision 1ps;

  cia_pkg::word_t shadow_store [DEPTH];
  int             shadow_count;
  cia_pkg::res_t  pending_results [$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    held_count   = 0;
    shadow_count = 0;
  end

  task automatic report_failure(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Applies one operation to the shadow array and returns the word it should answer.
  function automatic cia_pkg::res_t apply_array_op(cia_pkg::op_t op, int pos,
                                                   cia_pkg::word_t item);
    cia_pkg::res_t r;
    r.status     = 1'b1;
    r.read_value = '0;
    case (op)
      cia_pkg::OP_PUSH: begin
        if (shadow_count < DEPTH && item != cia_pkg::WORD_MIN &&
            item != cia_pkg::WORD_MAX) begin
          shadow_store[shadow_count] = item;
          shadow_count++;
          r.status = 1'b0;
        end
      end
      cia_pkg::OP_SET: begin
        if (pos < shadow_count) begin
          shadow_store[pos] = item;
          r.status = 1'b0;
        end
      end
      cia_pkg::OP_GET: begin
        if (pos < shadow_count) begin
          r.read_value = shadow_store[pos];
          r.status     = 1'b0;
        end else begin
          r.read_value = cia_pkg::WORD_MIN;
        end
      end
      default: begin
        if (pos < shadow_count) begin
          // later entries close the gap; the old top slot goes stale
          for (int i = pos; i + 1 < shadow_count; i++)
            shadow_store[i] = shadow_store[i + 1];
          shadow_count--;
          r.status = 1'b0;
        end
      end
    endcase
    r.entry_count = cia_pkg::COUNT_OUT_W'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin
    cia_pkg::res_t want;
    if (rst) begin
      shadow_count = 0;
      pending_results.delete();
    end else begin
      // output first: a word leaving now never belongs to the one just taken
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_failure("result word with no operation waiting");
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_failure($sformatf("status: got %b, expected %b", status, want.status));
          if (read_value !== want.read_value)
            report_failure($sformatf("read_value: got %h, expected %h",
                                     read_value, want.read_value));
          if (entry_count !== want.entry_count)
            report_failure($sformatf("entry_count: got %0d, expected %0d",
                                     entry_count, want.entry_count));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_array_op(operation, int'(position), value_in));
    end
    outstanding = pending_results.size();
    held_count  = shadow_count;
  end

endmodule

// ----- verif/compacting_int_array_test.sv -----
// Testbench top for the compacting integer array: clock, reset, stimulus and verdict.
module compacting_int_array_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 256;
  localparam int NUM_ITEMS    = 1500;
  localparam int CALM_ITEMS   = 150;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 300;

  typedef enum int {BALANCED, GROWING, SHRINKING} traffic_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         operation;
  logic [7:0]         position;
  logic signed [31:0] value_in;
  logic               out_valid;
  logic               out_ready;
  logic               status;
  logic signed [31:0] read_value;
  logic [8:0]         entry_count;

  int fail_count;
  int outstanding;
  int held_count;

  logic quiet;
  logic calm;
  logic long_hold_req;
  int   items_sent;
  int   stall_cycles = 0;

  compacting_int_array #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .position   (position),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value),
    .entry_count(entry_count)
  );

  compacting_int_array_check #(
    .DEPTH(DEPTH)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .position   (position),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value),
    .entry_count(entry_count),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .held_count (held_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic offer_word(cia_pkg::op_t op, logic [7:0] pos, cia_pkg::word_t item);
    if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    operation = op;
    position  = pos;
    value_in  = item;
    in_valid  = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Reserved and sign-boundary items turn up often enough to matter.
  function automatic cia_pkg::word_t pick_item();
    case ($urandom_range(0, 11))
      0:       return cia_pkg::WORD_MIN;
      1:       return cia_pkg::WORD_MAX;
      2:       return cia_pkg::WORD_MIN + 1;
      3:       return cia_pkg::WORD_MAX - 1;
      4:       return '0;
      5:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off on request, none near the end.
  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    traffic_t     traffic;
    cia_pkg::op_t op;
    int           roll;
    logic [7:0]   pos;
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = cia_pkg::OP_PUSH;
    position      = '0;
    value_in      = '0;
    quiet         = 1'b0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    items_sent    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty array, rejected pushes, then a small array to poke at
    offer_word(cia_pkg::OP_GET,    8'd0,   cia_pkg::word_t'(32'h1234_5678));
    offer_word(cia_pkg::OP_SET,    8'd0,   cia_pkg::word_t'(32'h1234_5678));
    offer_word(cia_pkg::OP_DELETE, 8'd0,   '0);
    offer_word(cia_pkg::OP_PUSH,   8'd0,   cia_pkg::WORD_MIN);
    offer_word(cia_pkg::OP_PUSH,   8'd0,   cia_pkg::WORD_MAX);
    offer_word(cia_pkg::OP_PUSH,   8'd0,   '0);
    offer_word(cia_pkg::OP_PUSH,   8'd255, -1);
    offer_word(cia_pkg::OP_PUSH,   8'd0,   cia_pkg::WORD_MIN + 1);
    offer_word(cia_pkg::OP_PUSH,   8'd0,   cia_pkg::WORD_MAX - 1);
    offer_word(cia_pkg::OP_PUSH,   8'd0,   cia_pkg::word_t'(32'h5555_5555));
    offer_word(cia_pkg::OP_PUSH,   8'd0,   cia_pkg::word_t'(32'hAAAA_AAAA));
    offer_word(cia_pkg::OP_SET,    8'd0,   cia_pkg::WORD_MIN);
    offer_word(cia_pkg::OP_SET,    8'd5,   cia_pkg::WORD_MAX);
    offer_word(cia_pkg::OP_SET,    8'd6,   '0);
    offer_word(cia_pkg::OP_GET,    8'd0,   '0);
    offer_word(cia_pkg::OP_GET,    8'd5,   '0);
    offer_word(cia_pkg::OP_GET,    8'd6,   '0);
    offer_word(cia_pkg::OP_GET,    8'd255, '0);
    offer_word(cia_pkg::OP_DELETE, 8'd2,   '0);
    offer_word(cia_pkg::OP_DELETE, 8'd4,   '0);
    offer_word(cia_pkg::OP_DELETE, 8'd0,   '0);
    offer_word(cia_pkg::OP_GET,    8'd0,   '0);
    offer_word(cia_pkg::OP_GET,    8'd2,   '0);
    offer_word(cia_pkg::OP_DELETE, 8'd255, '0);

    // fill to capacity while the receiver holds off, so the input backs up
    long_hold_req = 1'b1;
    while (held_count < DEPTH)
      offer_word(cia_pkg::OP_PUSH, 8'($urandom), pick_item());
    repeat (4) offer_word(cia_pkg::OP_PUSH, 8'($urandom), pick_item());
    offer_word(cia_pkg::OP_GET,    8'd255, '0);
    offer_word(cia_pkg::OP_SET,    8'd255, cia_pkg::WORD_MIN);
    offer_word(cia_pkg::OP_GET,    8'd255, '0);
    offer_word(cia_pkg::OP_DELETE, 8'd0,   '0);
    offer_word(cia_pkg::OP_GET,    8'd254, '0);
    offer_word(cia_pkg::OP_DELETE, 8'd254, '0);

    while (items_sent < NUM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       traffic = GROWING;
        1:       traffic = SHRINKING;
        default: traffic = BALANCED;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      repeat (40) begin
        if (items_sent >= NUM_ITEMS) break;
        calm = (items_sent >= NUM_ITEMS - CALM_ITEMS);
        roll = $urandom_range(0, 99);
        case (traffic)
          GROWING:   op = roll < 80 ? cia_pkg::OP_PUSH : roll < 88 ? cia_pkg::OP_SET :
                          roll < 95 ? cia_pkg::OP_GET : cia_pkg::OP_DELETE;
          SHRINKING: op = roll < 15 ? cia_pkg::OP_PUSH : roll < 25 ? cia_pkg::OP_SET :
                          roll < 40 ? cia_pkg::OP_GET : cia_pkg::OP_DELETE;
          default:   op = roll < 30 ? cia_pkg::OP_PUSH : roll < 50 ? cia_pkg::OP_SET :
                          roll < 80 ? cia_pkg::OP_GET : cia_pkg::OP_DELETE;
        endcase
        // mostly live indexes, now and then one at or past the count
        if (held_count > 0 && $urandom_range(0, 99) < 85)
          pos = 8'($urandom_range(0, held_count - 1));
        else if (held_count < DEPTH)
          pos = 8'($urandom_range(held_count, 255));
        else
          pos = 8'($urandom_range(0, 255));
        offer_word(op, pos, pick_item());
      end
    end
    in_valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/cia_pkg.sv
hdl/cia_mem.sv
hdl/cia_ctrl.sv
hdl/compacting_int_array.sv
verif/compacting_int_array_check.sv
verif/compacting_int_array_test.sv
